/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/pce_pkg.sv */
// Types, constants and record builders of the PCI config space enumerator.
package pce_pkg;

    localparam int MAX_DEVICES = 32;
    localparam int CAP_LIMIT   = 48;
    localparam int RES_MAX     = 3;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_COMPL = 1'b1;

    localparam logic       REG_BUS_FIRST = 1'b0;
    localparam logic       REG_BUS_LAST  = 1'b1;

    localparam logic [7:0]  CAP_ID_MSI   = 8'h05;
    localparam logic [7:0]  CAP_ID_MSIX  = 8'h11;
    localparam logic [7:0]  CAP_ID_PCIE  = 8'h10;
    localparam logic [7:0]  CAP_PTR_END  = 8'hFC;
    localparam logic [11:0] OFF_VENDOR   = 12'h000;
    localparam logic [11:0] OFF_DEVICE   = 12'h002;
    localparam logic [11:0] OFF_CLASS    = 12'h008;
    localparam logic [11:0] OFF_HDR      = 12'h00E;
    localparam logic [11:0] OFF_BAR0     = 12'h010;
    localparam logic [11:0] OFF_CAP_PTR  = 12'h034;
    localparam logic [15:0] VID_NONE     = 16'hFFFF;
    localparam logic [31:0] MEM_BAR_MASK = 32'hFFFF_FFF0;
    localparam logic [31:0] IO_BAR_MASK  = 32'hFFFF_FFFC;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [2:0]  LAST_FUNC    = 3'd7;
    localparam logic [4:0]  LAST_SLOT    = 5'd31;
    localparam logic [2:0]  LAST_BAR     = 3'd5;

    typedef enum logic [2:0] {
        KIND_RD8  = 3'd0,
        KIND_RD16 = 3'd1,
        KIND_RD32 = 3'd2,
        KIND_WR32 = 3'd3,
        KIND_DEV  = 3'd4,
        KIND_BAR  = 3'd5,
        KIND_DONE = 3'd6
    } kind_t;

    typedef enum logic [10:0] {
        PH_IDLE    = 11'b000_0000_0001,
        PH_VEN0    = 11'b000_0000_0010,
        PH_HDR     = 11'b000_0000_0100,
        PH_VENF    = 11'b000_0000_1000,
        PH_DEVID   = 11'b000_0001_0000,
        PH_CLASS   = 11'b000_0010_0000,
        PH_BARORIG = 11'b000_0100_0000,
        PH_BARMASK = 11'b000_1000_0000,
        PH_CAPPTR  = 11'b001_0000_0000,
        PH_CAPID   = 11'b010_0000_0000,
        PH_CAPNEXT = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  cur_bus;
        logic [4:0]  cur_slot;
        logic [2:0]  cur_func;
        logic        multi_func;
        logic [2:0]  bar_index;
        logic [31:0] bar_original;
        logic [31:0] ids_word;
        logic [31:0] class_word;
        logic [7:0]  cap_pointer;
        logic [5:0]  cap_steps;
        logic [7:0]  cap_msi;
        logic [7:0]  cap_msix;
        logic [7:0]  cap_pcie;
        logic [5:0]  found_count;
    } eng_state_t;

    localparam eng_state_t ST_RESET = '{phase: PH_IDLE, default: '0};

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  bus_num;
        logic [4:0]  slot_num;
        logic [2:0]  func_num;
        logic [11:0] reg_offset;
        logic [31:0] data_word;
        logic [31:0] extra_word;
        logic [3:0]  bar_flag_bits;
        logic [7:0]  msi_offset;
        logic [7:0]  msix_offset;
        logic [7:0]  pcie_offset;
        logic        last;
    } result_t;

    typedef result_t [RES_MAX-1:0] res_arr_t;

    typedef struct packed {
        logic       en;
        logic [1:0] cnt;
    } q_load_t;

    function automatic result_t mk_access(kind_t kind, eng_state_t st,
                                          logic [11:0] off, logic [31:0] data);
        result_t r;
        r            = '0;
        r.kind       = kind;
        r.bus_num    = st.cur_bus;
        r.slot_num   = st.cur_slot;
        r.func_num   = st.cur_func;
        r.reg_offset = off;
        r.data_word  = data;
        return r;
    endfunction

    function automatic result_t mk_done(logic [5:0] count);
        result_t r;
        r           = '0;
        r.kind      = KIND_DONE;
        r.data_word = {26'd0, count};
        return r;
    endfunction

    function automatic result_t mk_dev(eng_state_t st);
        result_t r;
        r             = '0;
        r.kind        = KIND_DEV;
        r.bus_num     = st.cur_bus;
        r.slot_num    = st.cur_slot;
        r.func_num    = st.cur_func;
        r.data_word   = st.ids_word;
        r.extra_word  = st.class_word;
        r.msi_offset  = st.cap_msi;
        r.msix_offset = st.cap_msix;
        r.pcie_offset = st.cap_pcie;
        return r;
    endfunction

    function automatic result_t mk_bar(eng_state_t st, logic [11:0] off,
                                       logic [31:0] size, logic [3:0] flags);
        result_t r;
        r               = '0;
        r.kind          = KIND_BAR;
        r.bus_num       = st.cur_bus;
        r.slot_num      = st.cur_slot;
        r.func_num      = st.cur_func;
        r.reg_offset    = off;
        r.data_word     = st.bar_original;
        r.extra_word    = size;
        r.bar_flag_bits = flags;
        return r;
    endfunction

endpackage

/* design/pce_if.sv */
// Handshake channels of the enumerator: request words in, result words out.
interface pce_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] read_data;

    modport source (output valid, cmd, read_data, input ready);
    modport sink   (input valid, cmd, read_data, output ready);
endinterface

interface pce_rsp_if import pce_pkg::*; ();
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [7:0]  bus_num;
    logic [4:0]  slot_num;
    logic [2:0]  func_num;
    logic [11:0] reg_offset;
    logic [31:0] data_word;
    logic [31:0] extra_word;
    logic [3:0]  bar_flag_bits;
    logic [7:0]  msi_offset;
    logic [7:0]  msix_offset;
    logic [7:0]  pcie_offset;
    logic        last;

    modport source (output valid, kind, bus_num, slot_num, func_num, reg_offset,
                    data_word, extra_word, bar_flag_bits, msi_offset, msix_offset,
                    pcie_offset, last, input ready);
    modport sink   (input valid, kind, bus_num, slot_num, func_num, reg_offset,
                    data_word, extra_word, bar_flag_bits, msi_offset, msix_offset,
                    pcie_offset, last, output ready);
endinterface

/* design/pce_step.sv */
// Next-state and result logic of the enumeration engine for one request word.
module pce_step import pce_pkg::*;
(
    input  eng_state_t  st,
    input  logic [7:0]  bus_first,
    input  logic [7:0]  bus_last,
    input  logic        cmd,
    input  logic [31:0] read_data,
    output eng_state_t  nx,
    output res_arr_t    res,
    output logic [1:0]  cnt
);

    logic [15:0] v16;
    logic [7:0]  v8;
    logic [11:0] bar_off;
    logic [11:0] bar_off_nx;
    logic [31:0] bar_lsb;
    logic [31:0] bar_size;
    logic [3:0]  bar_flags;
    logic        do_cap;
    logic        do_nf;
    logic        do_ns;

    assign v16     = read_data[15:0];
    assign v8      = read_data[7:0];
    assign bar_off = OFF_BAR0 + {7'd0, st.bar_index, 2'b00};

    always_comb
    begin
        nx         = st;
        res        = '0;
        cnt        = 2'd0;
        do_cap     = 1'b0;
        do_nf      = 1'b0;
        do_ns      = 1'b0;
        bar_lsb    = '0;
        bar_size   = '0;
        bar_flags  = '0;
        bar_off_nx = bar_off;

        if (cmd == CMD_START)
        begin
            if (st.phase == PH_IDLE)
            begin
                nx.found_count = '0;
                nx.cur_bus     = bus_first;
                nx.cur_slot    = '0;
                nx.cur_func    = '0;
                nx.multi_func  = 1'b0;
                if (bus_first > bus_last)
                begin
                    res[cnt] = mk_done(6'd0);
                    cnt      = cnt + 2'd1;
                end
                else
                begin
                    nx.phase = PH_VEN0;
                    res[cnt] = mk_access(KIND_RD16, nx, OFF_VENDOR, '0);
                    cnt      = cnt + 2'd1;
                end
            end
        end
        else
        begin
            unique case (st.phase)
                PH_VEN0:
                begin
                    if (v16 == VID_NONE || v16 == '0)
                        do_ns = 1'b1;
                    else
                    begin
                        nx.phase = PH_HDR;
                        res[cnt] = mk_access(KIND_RD8, nx, OFF_HDR, '0);
                        cnt      = cnt + 2'd1;
                    end
                end
                PH_HDR:
                begin
                    nx.multi_func = v8[7];
                    nx.cur_func   = '0;
                    nx.phase      = PH_VENF;
                    res[cnt]      = mk_access(KIND_RD16, nx, OFF_VENDOR, '0);
                    cnt           = cnt + 2'd1;
                end
                PH_VENF:
                begin
                    if (v16 == VID_NONE || v16 == '0)
                        do_nf = 1'b1;
                    else
                    begin
                        nx.ids_word = {16'd0, v16};
                        nx.phase    = PH_DEVID;
                        res[cnt]    = mk_access(KIND_RD16, nx, OFF_DEVICE, '0);
                        cnt         = cnt + 2'd1;
                    end
                end
                PH_DEVID:
                begin
                    nx.ids_word = {v16, st.ids_word[15:0]};
                    nx.phase    = PH_CLASS;
                    res[cnt]    = mk_access(KIND_RD32, nx, OFF_CLASS, '0);
                    cnt         = cnt + 2'd1;
                end
                PH_CLASS:
                begin
                    nx.class_word = read_data;
                    nx.bar_index  = '0;
                    nx.phase      = PH_BARORIG;
                    res[cnt]      = mk_access(KIND_RD32, nx, OFF_BAR0, '0);
                    cnt           = cnt + 2'd1;
                end
                PH_BARORIG:
                begin
                    nx.bar_original = read_data;
                    nx.phase        = PH_BARMASK;
                    res[cnt]        = mk_access(KIND_WR32, nx, bar_off, ALL_ONES);
                    cnt             = cnt + 2'd1;
                    res[cnt]        = mk_access(KIND_RD32, nx, bar_off, '0);
                    cnt             = cnt + 2'd1;
                end
                PH_BARMASK:
                begin
                    if (read_data != '0 && read_data != ALL_ONES)
                    begin
                        if (!st.bar_original[0])
                        begin
                            bar_lsb   = read_data & MEM_BAR_MASK;
                            bar_flags = st.bar_original[3:0];
                        end
                        else
                        begin
                            bar_lsb   = read_data & IO_BAR_MASK;
                            bar_flags = {2'b00, st.bar_original[1:0]};
                        end
                        bar_size = ~bar_lsb + 32'd1;
                    end
                    res[cnt] = mk_access(KIND_WR32, st, bar_off, st.bar_original);
                    cnt      = cnt + 2'd1;
                    res[cnt] = mk_bar(st, bar_off, bar_size, bar_flags);
                    cnt      = cnt + 2'd1;
                    if (st.bar_index < LAST_BAR)
                    begin
                        nx.bar_index = st.bar_index + 3'd1;
                        nx.phase     = PH_BARORIG;
                        bar_off_nx   = OFF_BAR0 + {7'd0, nx.bar_index, 2'b00};
                        res[cnt]     = mk_access(KIND_RD32, nx, bar_off_nx, '0);
                        cnt          = cnt + 2'd1;
                    end
                    else
                    begin
                        nx.cap_steps = '0;
                        nx.cap_msi   = '0;
                        nx.cap_msix  = '0;
                        nx.cap_pcie  = '0;
                        nx.phase     = PH_CAPPTR;
                        res[cnt]     = mk_access(KIND_RD8, nx, OFF_CAP_PTR, '0);
                        cnt          = cnt + 2'd1;
                    end
                end
                PH_CAPPTR, PH_CAPNEXT:
                begin
                    nx.cap_pointer = v8;
                    do_cap         = 1'b1;
                end
                PH_CAPID:
                begin
                    if (v8 == CAP_ID_MSI)
                        nx.cap_msi = st.cap_pointer;
                    else if (v8 == CAP_ID_MSIX)
                        nx.cap_msix = st.cap_pointer;
                    else if (v8 == CAP_ID_PCIE)
                        nx.cap_pcie = st.cap_pointer;
                    nx.cap_steps = st.cap_steps + 6'd1;
                    nx.phase     = PH_CAPNEXT;
                    res[cnt]     = mk_access(KIND_RD8, nx,
                                             {4'd0, st.cap_pointer} + 12'd1, '0);
                    cnt          = cnt + 2'd1;
                end
                default:
                begin
                end
            endcase
        end

        if (do_cap)
        begin
            if (nx.cap_pointer != '0 && nx.cap_pointer < CAP_PTR_END &&
                nx.cap_steps < 6'(CAP_LIMIT))
            begin
                nx.phase = PH_CAPID;
                res[cnt] = mk_access(KIND_RD8, nx, {4'd0, nx.cap_pointer}, '0);
                cnt      = cnt + 2'd1;
            end
            else
            begin
                res[cnt]       = mk_dev(nx);
                cnt            = cnt + 2'd1;
                nx.found_count = nx.found_count + 6'd1;
                if (nx.found_count >= 6'(MAX_DEVICES))
                begin
                    res[cnt] = mk_done(nx.found_count);
                    cnt      = cnt + 2'd1;
                    nx.phase = PH_IDLE;
                end
                else
                    do_nf = 1'b1;
            end
        end

        if (do_nf)
        begin
            if (nx.multi_func && nx.cur_func < LAST_FUNC)
            begin
                nx.cur_func = nx.cur_func + 3'd1;
                nx.phase    = PH_VENF;
                res[cnt]    = mk_access(KIND_RD16, nx, OFF_VENDOR, '0);
                cnt         = cnt + 2'd1;
            end
            else
                do_ns = 1'b1;
        end

        if (do_ns)
        begin
            nx.cur_func   = '0;
            nx.multi_func = 1'b0;
            if (nx.cur_slot == LAST_SLOT && nx.cur_bus == bus_last)
            begin
                res[cnt] = mk_done(nx.found_count);
                cnt      = cnt + 2'd1;
                nx.phase = PH_IDLE;
            end
            else
            begin
                if (nx.cur_slot < LAST_SLOT)
                    nx.cur_slot = nx.cur_slot + 5'd1;
                else
                begin
                    nx.cur_bus  = nx.cur_bus + 8'd1;
                    nx.cur_slot = '0;
                end
                nx.phase = PH_VEN0;
                res[cnt] = mk_access(KIND_RD16, nx, OFF_VENDOR, '0);
                cnt      = cnt + 2'd1;
            end
        end

        if (cnt != 2'd0)
            res[cnt - 2'd1].last = 1'b1;
    end

endmodule

/* design/pce_outq.sv */
// Three-entry result buffer that drains one result word per cycle while rsp is ready.
module pce_outq import pce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_load_t    ld,
    input  res_arr_t   ld_res,
    output logic       can_load,
    pce_rsp_if.source  rsp
);

    res_arr_t   q_reg;
    res_arr_t   q_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop      = rsp.valid && rsp.ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && rsp.ready);

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            cnt_next  = cnt_reg - 2'd1;
        end
        if (ld.en)
        begin
            q_next   = ld_res;
            cnt_next = ld.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign rsp.valid         = cnt_reg != 2'd0;
    assign rsp.kind          = q_reg[0].kind;
    assign rsp.bus_num       = q_reg[0].bus_num;
    assign rsp.slot_num      = q_reg[0].slot_num;
    assign rsp.func_num      = q_reg[0].func_num;
    assign rsp.reg_offset    = q_reg[0].reg_offset;
    assign rsp.data_word     = q_reg[0].data_word;
    assign rsp.extra_word    = q_reg[0].extra_word;
    assign rsp.bar_flag_bits = q_reg[0].bar_flag_bits;
    assign rsp.msi_offset    = q_reg[0].msi_offset;
    assign rsp.msix_offset   = q_reg[0].msix_offset;
    assign rsp.pcie_offset   = q_reg[0].pcie_offset;
    assign rsp.last          = q_reg[0].last;

endmodule

/* design/pci_config_space_enumerator.sv */
// Top level of the PCI config space enumerator.
//   channel | dir | handshake   | word
//   req     | in  | valid/ready | cmd, read_data
//   rsp     | out | valid/ready | access, device, BAR or done record
//   cfg     | in  | cfg_we      | cfg_index selects bus_first or bus_last
// A request word is held in the input register, then is decoded in one pass.
// Its 0 to 3 result words are buffered, then leave one per cycle while rsp is ready.
// Sustained rate: one word per cycle when each yields one result and rsp is ready; a word with
// more results waits while the single output port drains the result buffer to at most one entry.
// Reset leaves the engine idle with both bus registers at zero; stalls on rsp back up into req.
module pci_config_space_enumerator import pce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    pce_req_if.sink    req,
    pce_rsp_if.source  rsp
);

    logic [7:0]  bus_first_reg;
    logic [7:0]  bus_last_reg;
    logic        in_vld_reg;
    logic        in_vld_next;
    logic        cmd_reg;
    logic [31:0] data_reg;
    eng_state_t  st_reg;
    eng_state_t  st_next;
    eng_state_t  step_nx;
    res_arr_t    step_res;
    logic [1:0]  step_cnt;
    logic        can_load;
    logic        proc;
    logic        accept;
    q_load_t     ld;

    assign proc      = in_vld_reg && can_load;
    assign req.ready = !in_vld_reg || proc;
    assign accept    = req.valid && req.ready;
    assign ld.en     = proc;
    assign ld.cnt    = step_cnt;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (proc)
            in_vld_next = 1'b0;
        st_next = proc ? step_nx : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_first_reg <= '0;
            bus_last_reg  <= '0;
            in_vld_reg    <= 1'b0;
            st_reg        <= ST_RESET;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_BUS_FIRST)
                bus_first_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_BUS_LAST)
                bus_last_reg <= cfg_data;
            in_vld_reg <= in_vld_next;
            st_reg     <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            data_reg <= req.read_data;
        end
    end

    pce_step u_step
    (
        .st        (st_reg),
        .bus_first (bus_first_reg),
        .bus_last  (bus_last_reg),
        .cmd       (cmd_reg),
        .read_data (data_reg),
        .nx        (step_nx),
        .res       (step_res),
        .cnt       (step_cnt)
    );

    pce_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .ld_res   (step_res),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule

/* design/pce_checker.sv */
// Port-level checks of the enumerator and their binding to the top level.
`include "assert_macros.svh"

module pce_checker import pce_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_kind,
    input logic [7:0]  rsp_bus_num,
    input logic [4:0]  rsp_slot_num,
    input logic [2:0]  rsp_func_num,
    input logic [11:0] rsp_reg_offset,
    input logic [3:0]  rsp_bar_flag_bits,
    input logic [7:0]  rsp_msi_offset,
    input logic [7:0]  rsp_msix_offset,
    input logic [7:0]  rsp_pcie_offset
);

    logic is_access;

    assign is_access = rsp_kind == KIND_RD8 || rsp_kind == KIND_RD16 ||
                       rsp_kind == KIND_RD32 || rsp_kind == KIND_WR32;

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `ASSERT_IMPLY(a_done_target, clk, rst_n, rsp_valid && rsp_kind == KIND_DONE, rsp_bus_num == '0 && rsp_slot_num == '0 && rsp_func_num == '0)
    `ASSERT_IMPLY(a_dev_fields, clk, rst_n, rsp_valid && rsp_kind == KIND_DEV, rsp_reg_offset == '0 && rsp_bar_flag_bits == '0)
    `ASSERT_IMPLY(a_access_caps, clk, rst_n, rsp_valid && is_access, rsp_msi_offset == '0 && rsp_msix_offset == '0 && rsp_pcie_offset == '0)

endmodule

bind pci_config_space_enumerator pce_checker u_pce_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_kind          (rsp.kind),
    .rsp_bus_num       (rsp.bus_num),
    .rsp_slot_num      (rsp.slot_num),
    .rsp_func_num      (rsp.func_num),
    .rsp_reg_offset    (rsp.reg_offset),
    .rsp_bar_flag_bits (rsp.bar_flag_bits),
    .rsp_msi_offset    (rsp.msi_offset),
    .rsp_msix_offset   (rsp.msix_offset),
    .rsp_pcie_offset   (rsp.pcie_offset)
);
